>>> src/assert_macros.svh
// Assertion macros shared by the RTL files of the block decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> src/dxtd_pkg.sv
// Shared types and constants of the DXT1/DXT3 block decoder.
`default_nettype none

package dxtd_pkg;

  localparam int COORD_W    = 12;
  localparam int ARGB_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  // One classified block, ready for pixel emission.
  typedef struct packed {
    logic [3:0][ARGB_W-1:0] palette;
    logic [31:0]            indices;
    logic [63:0]            alpha;
    logic                   dxt3;
    logic [COORD_W-1:0]     base_x;
    logic [COORD_W-1:0]     base_y;
    logic [1:0]             col_last;
    logic [1:0]             row_last;
    logic                   final_block;
  } blk_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

`default_nettype wire

>>> src/dxt_block_decoder.sv
// DXT1/DXT3 block decoder: one compressed 4x4 block in, one ARGB32 pixel per beat out.
//
// Input channel (in_valid/in_ready): one beat carries a whole compressed block, in raster
// block order. Output channel (out_valid/out_ready): one beat per visible pixel, row by
// row within the block, with block_last on the block's final pixel and image_last on the
// final pixel of the image. Configuration channel (cfg_valid/cfg_ready) is always ready;
// index 0 selects DXT3, 1 and 2 set width and height. Any write to index 0, 1 or 2
// restarts at block 0,0. Writes must only be issued while no block is in flight.
// The first pixel of a block passes the queue, the emitter's block register and the
// output register. Throughput: one pixel per cycle while the receiver takes them,
// whether the block is full or clipped at an edge. The pixel emitter sets the rate;
// the front end builds a palette combinationally and parks it in a two-entry queue,
// so new blocks are taken while the emitter is still busy.
// Reset (synchronous, active low) clears the queue and the output register and restores
// DXT1, 256x256 and block 0,0. When the receiver stalls, the output register holds its
// pixel, the emitter pauses and the queue fills; in_ready drops once the queue is full.
`default_nettype none
`include "assert_macros.svh"

module dxt_block_decoder #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dxtd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dxtd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     in_alpha_bits,
  input  logic [15:0]                     in_endpoint_zero,
  input  logic [15:0]                     in_endpoint_one,
  input  logic [31:0]                     in_color_indices,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [dxtd_pkg::COORD_W-1:0]    out_pixel_x,
  output logic [dxtd_pkg::COORD_W-1:0]    out_pixel_y,
  output logic [dxtd_pkg::ARGB_W-1:0]     out_argb,
  output logic                            out_block_last,
  output logic                            out_image_last
);
  import dxtd_pkg::*;

  fifo_stat_t q_stat;
  blk_entry_t wr_entry;
  blk_entry_t rd_entry;
  logic       q_push;
  logic       q_pop;

  assign cfg_ready = 1'b1;

  dxtd_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_alpha_bits   (in_alpha_bits),
    .in_endpoint_zero(in_endpoint_zero),
    .in_endpoint_one (in_endpoint_one),
    .in_color_indices(in_color_indices),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_entry         (wr_entry)
  );

  dxtd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_entry(wr_entry),
    .pop     (q_pop),
    .rd_entry(rd_entry),
    .stat    (q_stat)
  );

  dxtd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_entry       (rd_entry),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_argb      (out_argb),
    .out_block_last(out_block_last),
    .out_image_last(out_image_last)
  );

  // The end of the image always closes a block.
  `ASSERT_SAME(a_image_last_in_block, clk, rst_n, out_valid, !out_image_last || out_block_last)
  // The queue cannot report empty and full together.
  `ASSERT_SAME(a_queue_status, clk, rst_n, 1'b1, !(q_stat.empty && q_stat.full))
  // Within a block the emitter delivers a pixel every cycle the receiver takes one.
  `ASSERT_NEXT(a_block_streams, clk, rst_n, out_valid && out_ready && !out_block_last, out_valid)

endmodule

`default_nettype wire

>>> src/dxtd_front.sv
// Front end: configuration registers, block position tracking and palette build.
`default_nettype none

module dxtd_front #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [dxtd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dxtd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     in_alpha_bits,
  input  logic [15:0]                     in_endpoint_zero,
  input  logic [15:0]                     in_endpoint_one,
  input  logic [31:0]                     in_color_indices,
  input  dxtd_pkg::fifo_stat_t            q_stat,
  output logic                            q_push,
  output dxtd_pkg::blk_entry_t            q_entry
);
  import dxtd_pkg::*;

  localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
  localparam int CNT_W   = DIM_W - 1;
  localparam int BLK_RAW = $clog2((MAX_DIMENSION + 3) / 4);
  localparam int BLK_W   = (BLK_RAW > 0) ? BLK_RAW : 1;
  localparam int RST_DIM = (MAX_DIMENSION < 256) ? MAX_DIMENSION : 256;

  logic             dxt3_r;
  logic [DIM_W-1:0] w_eff_r;
  logic [DIM_W-1:0] h_eff_r;
  logic [BLK_W-1:0] col_r;
  logic [BLK_W-1:0] row_r;

  logic [DIM_W-1:0] dim_eff;
  logic             cfg_hit;
  logic [DIM_W:0]   w_ext;
  logic [DIM_W:0]   h_ext;
  logic [CNT_W-1:0] col_max;
  logic [CNT_W-1:0] row_max;
  logic             last_col;
  logic             last_row;
  logic [DIM_W-1:0] rem_x;
  logic [DIM_W-1:0] rem_y;

  function automatic logic [23:0] expand565(input logic [15:0] c);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = c[15:11];
    g6 = c[10:5];
    b5 = c[4:0];
    return {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
  endfunction

  // floor(s / 3) for s below 768 through the reciprocal 683 / 2048.
  function automatic logic [7:0] third(input logic [9:0] s);
    logic [19:0] p;
    p = 20'(s) * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] blend21(input logic [7:0] a, input logic [7:0] b);
    logic [9:0] s;
    s = {1'b0, a, 1'b0} + {2'b00, b};
    return third(s);
  endfunction

  function automatic logic [7:0] half(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

  // A zero dimension counts as one and anything above the maximum is clamped.
  always_comb begin
    if (cfg_data == '0) begin
      dim_eff = DIM_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_DIMENSION)) begin
      dim_eff = DIM_W'(MAX_DIMENSION);
    end else begin
      dim_eff = DIM_W'(cfg_data);
    end
  end

  always_comb begin
    case (cfg_index)
      CFG_FORMAT, CFG_WIDTH, CFG_HEIGHT: cfg_hit = cfg_valid;
      default:                           cfg_hit = 1'b0;
    endcase
  end

  assign w_ext    = {1'b0, w_eff_r} + (DIM_W + 1)'(3);
  assign h_ext    = {1'b0, h_eff_r} + (DIM_W + 1)'(3);
  assign col_max  = w_ext[DIM_W:2] - CNT_W'(1);
  assign row_max  = h_ext[DIM_W:2] - CNT_W'(1);
  assign last_col = (CNT_W'(col_r) == col_max);
  assign last_row = (CNT_W'(row_r) == row_max);
  assign rem_x    = w_eff_r - DIM_W'({col_r, 2'b00});
  assign rem_y    = h_eff_r - DIM_W'({row_r, 2'b00});

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    logic [23:0] e0;
    logic [23:0] e1;
    logic [7:0]  r0, g0, b0, r1, g1, b1;
    e0 = expand565(in_endpoint_zero);
    e1 = expand565(in_endpoint_one);
    {r0, g0, b0} = e0;
    {r1, g1, b1} = e1;
    q_entry.palette[0] = {8'hFF, e0};
    q_entry.palette[1] = {8'hFF, e1};
    if (in_endpoint_zero > in_endpoint_one) begin
      q_entry.palette[2] = {8'hFF, blend21(r0, r1), blend21(g0, g1), blend21(b0, b1)};
      q_entry.palette[3] = {8'hFF, blend21(r1, r0), blend21(g1, g0), blend21(b1, b0)};
    end else begin
      q_entry.palette[2] = {8'hFF, half(r0, r1), half(g0, g1), half(b0, b1)};
      q_entry.palette[3] = '0;
    end
    q_entry.indices     = in_color_indices;
    q_entry.alpha       = in_alpha_bits;
    q_entry.dxt3        = dxt3_r;
    q_entry.base_x      = COORD_W'({col_r, 2'b00});
    q_entry.base_y      = COORD_W'({row_r, 2'b00});
    q_entry.col_last    = (rem_x >= DIM_W'(4)) ? 2'd3 : (rem_x[1:0] - 2'd1);
    q_entry.row_last    = (rem_y >= DIM_W'(4)) ? 2'd3 : (rem_y[1:0] - 2'd1);
    q_entry.final_block = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dxt3_r  <= 1'b0;
      w_eff_r <= DIM_W'(RST_DIM);
      h_eff_r <= DIM_W'(RST_DIM);
      col_r   <= '0;
      row_r   <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        CFG_FORMAT: dxt3_r  <= cfg_data[0];
        CFG_WIDTH:  w_eff_r <= dim_eff;
        CFG_HEIGHT: h_eff_r <= dim_eff;
        default:    dxt3_r  <= dxt3_r;
      endcase
      // Any register write restarts the image at the top-left block.
      col_r <= '0;
      row_r <= '0;
    end else if (q_push) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + BLK_W'(1);
      end else begin
        col_r <= col_r + BLK_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/dxtd_fifo.sv
// Short queue of classified blocks between the front end and the pixel emitter.
`default_nettype none

module dxtd_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  dxtd_pkg::blk_entry_t wr_entry,
  input  logic                 pop,
  output dxtd_pkg::blk_entry_t rd_entry,
  output dxtd_pkg::fifo_stat_t stat
);
  import dxtd_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  blk_entry_t       mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign rd_entry   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/dxtd_back.sv
// Back end: walks the visible pixels of a block and drives the output register.
`default_nettype none

module dxtd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dxtd_pkg::blk_entry_t         q_entry,
  input  dxtd_pkg::fifo_stat_t         q_stat,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dxtd_pkg::COORD_W-1:0] out_pixel_x,
  output logic [dxtd_pkg::COORD_W-1:0] out_pixel_y,
  output logic [dxtd_pkg::ARGB_W-1:0]  out_argb,
  output logic                         out_block_last,
  output logic                         out_image_last
);
  import dxtd_pkg::*;

  blk_entry_t         cur_r;
  logic               cur_valid_r;
  logic [1:0]         px_r;
  logic [1:0]         py_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] pixel_x_r;
  logic [COORD_W-1:0] pixel_y_r;
  logic [ARGB_W-1:0]  argb_r;
  logic               block_last_r;
  logic               image_last_r;

  logic              adv;
  logic              emit;
  logic              pix_last;
  logic              load;
  logic [3:0]        k;
  logic [1:0]        sel;
  logic [3:0]        nib;
  logic [ARGB_W-1:0] argb_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign emit     = adv && cur_valid_r;
  assign pix_last = (px_r == cur_r.col_last) && (py_r == cur_r.row_last);
  // The next block is taken in the same cycle the last pixel leaves.
  assign load     = (!cur_valid_r || (emit && pix_last)) && !q_stat.empty;
  assign q_pop    = load;

  assign k   = {py_r, px_r};
  assign sel = cur_r.indices[{k, 1'b0} +: 2];
  assign nib = cur_r.alpha[{k, 2'b00} +: 4];

  always_comb begin
    argb_nxt = cur_r.palette[sel];
    if (cur_r.dxt3) begin
      argb_nxt[31:24] = {nib, nib};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      px_r        <= '0;
      py_r        <= '0;
    end else if (load) begin
      cur_r       <= q_entry;
      cur_valid_r <= 1'b1;
      px_r        <= '0;
      py_r        <= '0;
    end else if (emit) begin
      if (pix_last) begin
        cur_valid_r <= 1'b0;
      end else if (px_r == cur_r.col_last) begin
        px_r <= '0;
        py_r <= py_r + 2'd1;
      end else begin
        px_r <= px_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end
    if (emit) begin
      pixel_x_r    <= cur_r.base_x + COORD_W'(px_r);
      pixel_y_r    <= cur_r.base_y + COORD_W'(py_r);
      argb_r       <= argb_nxt;
      block_last_r <= pix_last;
      image_last_r <= pix_last && cur_r.final_block;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = pixel_x_r;
  assign out_pixel_y    = pixel_y_r;
  assign out_argb       = argb_r;
  assign out_block_last = block_last_r;
  assign out_image_last = image_last_r;

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the DXT1/DXT3 block decoder: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
  import dxtd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 4;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_COUNT  = 6;
  localparam int PHASE_BLOCKS = 15;

  typedef struct packed {
    logic [63:0] alpha;
    logic [15:0] ep0;
    logic [15:0] ep1;
    logic [31:0] idx;
  } block_t;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] argb;
    logic        blk_last;
    logic        img_last;
  } pixel_t;

  // A row carries the image setup it needs; typed rows give the argb of every pixel.
  typedef struct packed {
    logic        dxt3;
    logic [12:0] w;
    logic [12:0] h;
    logic [63:0] alpha;
    logic [15:0] ep0;
    logic [15:0] ep1;
    logic [31:0] idx;
    logic        typed;
    logic [31:0] argb;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [63:0]           in_alpha_bits = '0;
  logic [15:0]           in_endpoint_zero = '0;
  logic [15:0]           in_endpoint_one = '0;
  logic [31:0]           in_color_indices = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COORD_W-1:0]    out_pixel_x;
  logic [COORD_W-1:0]    out_pixel_y;
  logic [ARGB_W-1:0]     out_argb;
  logic                  out_block_last;
  logic                  out_image_last;

  // Predictor state: configuration and the position of the next block.
  logic        fmt_dxt3 = 1'b0;
  logic [12:0] width_reg = 13'd256;
  logic [12:0] height_reg = 13'd256;
  logic [9:0]  blk_col = '0;
  logic [9:0]  blk_row = '0;

  pixel_t      pending_pixels [$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 83;
  pixel_t      want_px;
  pixel_t      got_px;
  dir_row_t    dir_tab [24];

  dxt_block_decoder uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_alpha_bits    (in_alpha_bits),
    .in_endpoint_zero (in_endpoint_zero),
    .in_endpoint_one  (in_endpoint_one),
    .in_color_indices (in_color_indices),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_argb         (out_argb),
    .out_block_last   (out_block_last),
    .out_image_last   (out_image_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [12:0] v);
    if (v == 13'd0) return 1;
    if (v > 13'd4096) return 4096;
    return 32'(v);
  endfunction

  // RGB565 to RGB888 by replicating the top bits into the vacated low bits.
  function automatic logic [23:0] widen565(input logic [15:0] c);
    return {c[15:11], c[15:13], c[10:5], c[10:9], c[4:0], c[4:2]};
  endfunction

  function automatic void decode_block(input block_t blk, input bit typed,
                                       input logic [31:0] typed_argb);
    int unsigned w, h, bw, bh, x, y, k, a0, a1;
    logic [23:0] rgb0, rgb1;
    logic [31:0] pal [4];
    logic [31:0] pix;
    pixel_t      p;
    bit          final_blk;
    w  = clamp_dim(width_reg);
    h  = clamp_dim(height_reg);
    bw = (w + 3) / 4;
    bh = (h + 3) / 4;
    if (blk_col >= bw || blk_row >= bh) begin
      blk_col = '0;
      blk_row = '0;
    end
    final_blk = (blk_col == bw - 1) && (blk_row == bh - 1);
    rgb0   = widen565(blk.ep0);
    rgb1   = widen565(blk.ep1);
    pal[0] = {8'hFF, rgb0};
    pal[1] = {8'hFF, rgb1};
    pal[2] = 32'hFF00_0000;
    pal[3] = (blk.ep0 > blk.ep1) ? 32'hFF00_0000 : 32'h0;
    for (int ch = 0; ch < 3; ch++) begin
      a0 = rgb0[8*ch +: 8];
      a1 = rgb1[8*ch +: 8];
      if (blk.ep0 > blk.ep1) begin
        pal[2][8*ch +: 8] = 8'((2 * a0 + a1) / 3);
        pal[3][8*ch +: 8] = 8'((a0 + 2 * a1) / 3);
      end else begin
        pal[2][8*ch +: 8] = 8'((a0 + a1) / 2);
      end
    end
    for (int py = 0; py < 4; py++) begin
      for (int pxi = 0; pxi < 4; pxi++) begin
        x = blk_col * 4 + pxi;
        y = blk_row * 4 + py;
        k = py * 4 + pxi;
        if (x < w && y < h) begin
          pix = pal[blk.idx[2*k +: 2]];
          if (fmt_dxt3) pix[31:24] = blk.alpha[4*k +: 4] * 8'd17;
          if (typed) pix = typed_argb;
          p = '{12'(x), 12'(y), pix, 1'b0, 1'b0};
          pending_pixels.push_back(p);
        end
      end
    end
    // Every block has at least one visible pixel, so the tail is this block's.
    pending_pixels[pending_pixels.size() - 1].blk_last = 1'b1;
    pending_pixels[pending_pixels.size() - 1].img_last = final_blk;
    if (blk_col + 1 >= bw) begin
      blk_col = '0;
      blk_row = (blk_row + 1 >= bh) ? 10'd0 : blk_row + 10'd1;
    end else begin
      blk_col = blk_col + 10'd1;
    end
  endfunction

  function automatic block_t rand_block();
    block_t b;
    b.alpha = {$urandom, $urandom};
    b.idx   = $urandom;
    b.ep0   = 16'($urandom);
    b.ep1   = 16'($urandom);
    case ($urandom_range(7))
      0: b.ep1 = b.ep0;
      1: b.ep0 = 16'hFFFF;
      2: b.ep1 = 16'h0000;
      3: b.idx = {16{2'($urandom_range(3))}};
      default: ;
    endcase
    return b;
  endfunction

  task automatic send_block(input block_t blk, input bit typed, input logic [31:0] typed_argb);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid         <= 1'b1;
    in_alpha_bits    <= blk.alpha;
    in_endpoint_zero <= blk.ep0;
    in_endpoint_one  <= blk.ep1;
    in_color_indices <= blk.idx;
    do @(posedge clk); while (!in_ready);
    decode_block(blk, typed, typed_argb);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FORMAT: fmt_dxt3 = data[0];
      CFG_WIDTH:  width_reg = data;
      CFG_HEIGHT: height_reg = data;
      default: ;
    endcase
    if (idx != CFG_SPARE) begin
      blk_col = '0;
      blk_row = '0;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every predicted pixel is out, then let the pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input pixel_t want, input pixel_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected x=%0d y=%0d argb=%08h bl=%0b il=%0b",
               what, want.x, want.y, want.argb, want.blk_last, want.img_last);
      $display("%s: got      x=%0d y=%0d argb=%08h bl=%0b il=%0b",
               what, got.x, got.y, got.argb, got.blk_last, got.img_last);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_px = '{out_pixel_x, out_pixel_y, out_argb, out_block_last, out_image_last};
      if (pending_pixels.size() == 0) begin
        want_px = 'x;
        report_mismatch("unexpected pixel", want_px, got_px);
      end else begin
        want_px = pending_pixels.pop_front();
        if (want_px !== got_px) report_mismatch("pixel mismatch", want_px, got_px);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t    r;
    block_t      blk;
    logic [12:0] wdim, hdim;
    dir_tab = '{
      // Reset setup, DXT1: plain endpoints, every palette slot, both blend modes.
      '{0, 256, 256, 64'h0, 16'h0000, 16'h0000, 32'h00000000, 1, 32'hFF000000},
      '{0, 256, 256, 64'h0, 16'hFFFF, 16'h0000, 32'h00000000, 1, 32'hFFFFFFFF},
      '{0, 256, 256, 64'h0, 16'hFFFF, 16'h0000, 32'h55555555, 1, 32'hFF000000},
      '{0, 256, 256, 64'h0, 16'hFFFF, 16'h0000, 32'hAAAAAAAA, 1, 32'hFFAAAAAA},
      '{0, 256, 256, 64'h0, 16'hFFFF, 16'h0000, 32'hFFFFFFFF, 1, 32'hFF555555},
      '{0, 256, 256, 64'h0, 16'h0000, 16'hFFFF, 32'hAAAAAAAA, 1, 32'hFF7F7F7F},
      '{0, 256, 256, 64'h0, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1, 32'h00000000},
      '{0, 256, 256, 64'h0, 16'h1234, 16'h1234, 32'hFFFFFFFF, 1, 32'h00000000},
      '{0, 256, 256, 64'h0, 16'hF800, 16'h07E0, 32'hE4E4E4E4, 0, 32'h0},
      '{0, 256, 256, 64'h0, 16'h001F, 16'hF800, 32'h1B1B1B1B, 0, 32'h0},
      // DXT3: alpha nibbles override, transparent slot included.
      '{1, 256, 256, 64'h0, 16'hFFFF, 16'h0000, 32'h00000000, 1, 32'h00FFFFFF},
      '{1, 256, 256, '1, 16'hFFFF, 16'h0000, 32'h00000000, 1, 32'hFFFFFFFF},
      '{1, 256, 256, '1, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1, 32'hFF000000},
      '{1, 256, 256, 64'h0123456789ABCDEF, 16'h7BEF, 16'h39E7, 32'h9C63D2B4, 0, 32'h0},
      '{1, 256, 256, 64'h8888888888888888, 16'hFFFF, 16'h0000, 32'h0, 1, 32'h88FFFFFF},
      // 6x5 image: clipped edge blocks, end of image, then wrap to the first block.
      '{0, 6, 5, 64'h0, 16'hA5A5, 16'h5A5A, 32'h0F0F0F0F, 0, 32'h0},
      '{0, 6, 5, 64'h0, 16'h5A5A, 16'hA5A5, 32'hF0F0F0F0, 0, 32'h0},
      '{0, 6, 5, 64'h0, 16'hC0DE, 16'h0BAD, 32'h3C3C3C3C, 0, 32'h0},
      '{0, 6, 5, 64'h0, 16'h4321, 16'h8765, 32'hC3C3C3C3, 0, 32'h0},
      '{0, 6, 5, 64'h0, 16'hFFFF, 16'hFFFE, 32'h12345678, 0, 32'h0},
      // Zero dimensions act as one pixel; oversized ones clamp to the maximum.
      '{0, 0, 0, 64'h0, 16'hFFFF, 16'h0000, 32'h00000000, 1, 32'hFFFFFFFF},
      '{1, 8191, 8191, 64'hFEDCBA9876543210, 16'h8410, 16'hC618, 32'h12345678, 0, 32'h0},
      '{1, 8191, 8191, 64'hF0F0F0F00F0F0F0F, 16'h0000, 16'h0001, 32'h87654321, 0, 32'h0},
      '{0, 4096, 1, 64'h0, 16'hFFFF, 16'hFFFE, 32'h33CC33CC, 0, 32'h0}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      if (r.dxt3 != fmt_dxt3 || r.w != width_reg || r.h != height_reg) begin
        settle();
        if (r.dxt3 != fmt_dxt3) write_reg(CFG_FORMAT, {12'd0, r.dxt3});
        if (r.w != width_reg) write_reg(CFG_WIDTH, r.w);
        if (r.h != height_reg) write_reg(CFG_HEIGHT, r.h);
      end
      blk = '{r.alpha, r.ep0, r.ep1, r.idx};
      send_block(blk, r.typed, r.argb);
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      settle();
      send_idle_pct = (ph < 2) ? 17 : (ph < 4) ? 83 : 0;
      recv_idle_pct = (ph < 2) ? 83 : (ph < 4) ? 17 : 0;
      case (ph)
        1: begin
          wdim = 13'h1FFF;
          hdim = 13'd3;
        end
        3: begin
          wdim = 13'd1;
          hdim = 13'd4096;
        end
        default: begin
          wdim = 13'($urandom_range(13, 0));
          hdim = 13'($urandom_range(13, 0));
        end
      endcase
      write_reg(CFG_FORMAT, {12'($urandom), ph[0]});
      write_reg(CFG_WIDTH, wdim);
      write_reg(CFG_HEIGHT, hdim);
      for (int i = 0; i < PHASE_BLOCKS; i++) begin
        // A write to the unused index must leave the block position alone.
        if (i == 7) begin
          settle();
          write_reg(CFG_SPARE, 13'($urandom));
        end
        send_block(rand_block(), 1'b0, 32'h0);
      end
    end

    settle();
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
